FILE: hdl/ecl_pkg.sv
// shared types, constants and helpers for the encoder linearizer and pll tracker
package ecl_pkg;

    localparam int CPR_BITS       = 14;
    localparam int TBL_BITS       = 7;
    localparam int SEG_BITS       = CPR_BITS - TBL_BITS;
    localparam int TBL_ENTRIES    = 1 << TBL_BITS;
    localparam int SETTLE_BITS    = 5;
    localparam int SETTLE_SAMPLES = 20;
    localparam int POS_BITS       = 30;
    localparam int VEL_BITS       = 40;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 40;

    localparam logic [CPR_BITS-1:0] HALF_TURN = 14'd8192;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_BITS-1:0] CFG_REVERSE = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ZERO    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_POLES   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KP      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KI      = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PERIOD  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SNAP    = 3'd6;

    typedef struct packed {
        logic        reverse;
        logic [13:0] zero_offset;
        logic [6:0]  pole_pairs;
        logic [15:0] kp_dt;
        logic [23:0] ki_dt;
        logic [23:0] sample_period;
        logic [39:0] vel_floor;
    } ecl_cfg_t;

    typedef struct packed {
        logic                en;
        logic [TBL_BITS-1:0] addr;
        logic [15:0]         data;
    } ecl_ram_wr_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD_A, ST_RD_B, ST_INTERP, ST_COUNT, ST_ELEC, ST_MUL_LO, ST_MUL_HI,
        ST_SUM, ST_PRED, ST_ERR, ST_KP, ST_KI, ST_VEL, ST_SNAP, ST_OUT
    } ecl_state_t;

    // reduce a difference into a half turn; plus half turn stays positive for d > 0
    function automatic logic signed [CPR_BITS:0] half_wrap(input logic signed [25:0] d);
        logic [CPR_BITS-1:0] m;
        m = d[CPR_BITS-1:0];
        if (m == HALF_TURN && !d[25])
            half_wrap = $signed({1'b0, m});
        else
            half_wrap = $signed({m[CPR_BITS-1], m});
    endfunction

endpackage

FILE: hdl/ecl_cfg_regs.sv
// configuration register file
module ecl_cfg_regs
    import ecl_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    output ecl_cfg_t                 cfg
);

    ecl_cfg_t cfg_reg;

    // register writes, unknown indexes ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reverse       <= 1'b0;
            cfg_reg.zero_offset   <= 14'd0;
            cfg_reg.pole_pairs    <= 7'd7;
            cfg_reg.kp_dt         <= 16'd4116;
            cfg_reg.ki_dt         <= 24'd1292014;
            cfg_reg.sample_period <= 24'd839;
            cfg_reg.vel_floor     <= 40'd1292014;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_REVERSE: cfg_reg.reverse       <= cfg_wdata[0];
                CFG_ZERO:    cfg_reg.zero_offset   <= cfg_wdata[13:0];
                CFG_POLES:   cfg_reg.pole_pairs    <= cfg_wdata[6:0];
                CFG_KP:      cfg_reg.kp_dt         <= cfg_wdata[15:0];
                CFG_KI:      cfg_reg.ki_dt         <= cfg_wdata[23:0];
                CFG_PERIOD:  cfg_reg.sample_period <= cfg_wdata[23:0];
                CFG_SNAP:    cfg_reg.vel_floor     <= cfg_wdata[39:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/ecl_offset_ram.sv
// offset table memory with per-entry valid bits, unwritten entries read as zero
module ecl_offset_ram
    import ecl_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  ecl_ram_wr_t         wr,
    input  logic [TBL_BITS-1:0] rd_addr,
    output logic [15:0]         rd_data
);

    logic [15:0]            mem [TBL_ENTRIES];
    logic [TBL_ENTRIES-1:0] valid_reg;
    logic [15:0]            q_reg;
    logic                   q_valid_reg;

    // storage write and registered read
    always_ff @(posedge aclk) begin
        if (wr.en)
            mem[wr.addr] <= wr.data;
        q_reg <= mem[rd_addr];
    end

    // valid bits cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            q_valid_reg <= 1'b0;
        end else begin
            if (wr.en)
                valid_reg[wr.addr] <= 1'b1;
            q_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = q_valid_reg ? q_reg : 16'd0;

endmodule

FILE: hdl/ecl_core.sv
// sequencer and datapath: interpolation, settling, turn count and pll update
module ecl_core
    import ecl_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  ecl_cfg_t            cfg,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [39:0]         s_tdata,
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [135:0]        m_tdata,
    output logic                m_tuser,
    output ecl_ram_wr_t         ram_wr,
    output logic [TBL_BITS-1:0] ram_rd_addr,
    input  logic [15:0]         ram_rd_data
);

    ecl_state_t state_reg, state_next;

    logic                    in_acc;
    logic                    out_free;
    logic [CPR_BITS-1:0]     in_raw;

    // item working registers
    logic                    load_reg;
    logic [CPR_BITS-1:0]     raw_reg;
    logic [15:0]             off1_reg;
    logic signed [24:0]      prod_reg;
    logic [CPR_BITS-1:0]     cnt_reg;
    logic [CPR_BITS-1:0]     elec_reg;
    logic                    res_valid_reg;
    logic [43:0]             mlo_reg;
    logic signed [44:0]      mhi_reg;
    logic signed [63:0]      full_reg;
    logic signed [41:0]      pred_reg;
    logic signed [CPR_BITS:0] err_reg;
    logic signed [31:0]      kp_reg;
    logic signed [39:0]      ki_reg;
    logic signed [39:0]      vsat_reg;

    // tracker state
    logic [SETTLE_BITS-1:0]  settle_reg;
    logic [CPR_BITS-1:0]     prev_reg;
    logic [POS_BITS-1:0]     pos_reg;
    logic signed [39:0]      vel_reg;
    logic [31:0]             turn_reg;

    // result register
    logic                    m_tvalid_reg;
    logic [135:0]            m_tdata_reg;
    logic                    m_tuser_reg;

    // combinational datapath terms
    logic signed [16:0]      diff;
    logic signed [16:0]      interp;
    logic signed [17:0]      cnt_full;
    logic [20:0]             elec_full;
    logic signed [CPR_BITS:0] dwrap;
    logic signed [25:0]      perr;
    logic signed [40:0]      vsum;
    logic [39:0]             vmag;
    logic signed [41:0]      pos_sum;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign in_raw   = s_tdata[13:0];

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_acc) state_next = s_tuser ? ST_OUT : ST_RD_A;
            ST_RD_A:   state_next = ST_RD_B;
            ST_RD_B:   state_next = ST_INTERP;
            ST_INTERP: state_next = ST_COUNT;
            ST_COUNT:  state_next = ST_ELEC;
            ST_ELEC:   state_next = (settle_reg != '0) ? ST_OUT : ST_MUL_LO;
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_SUM;
            ST_SUM:    state_next = ST_PRED;
            ST_PRED:   state_next = ST_ERR;
            ST_ERR:    state_next = ST_KP;
            ST_KP:     state_next = ST_KI;
            ST_KI:     state_next = ST_VEL;
            ST_VEL:    state_next = ST_SNAP;
            ST_SNAP:   state_next = ST_OUT;
            ST_OUT:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // memory access control
    always_comb begin
        ram_wr.en   = 1'b0;
        ram_wr.addr = s_tdata[20:14];
        ram_wr.data = s_tdata[36:21];
        ram_rd_addr = raw_reg[CPR_BITS-1:SEG_BITS];
        unique case (state_reg)
            ST_IDLE: ram_wr.en = in_acc && s_tuser;
            ST_RD_B: ram_rd_addr = raw_reg[CPR_BITS-1:SEG_BITS] + 1'b1;
            default: ;
        endcase
    end

    // datapath terms
    always_comb begin
        diff      = $signed({ram_rd_data[15], ram_rd_data}) - $signed({off1_reg[15], off1_reg});
        interp    = $signed({off1_reg[15], off1_reg}) + 17'(prod_reg >>> SEG_BITS);
        cnt_full  = $signed({4'd0, raw_reg}) - $signed({interp[16], interp})
                    - $signed({4'd0, cfg.zero_offset});
        elec_full = cnt_reg * cfg.pole_pairs;
        dwrap     = half_wrap(26'($signed({1'b0, cnt_reg}) - $signed({1'b0, prev_reg})));
        perr      = $signed({12'd0, cnt_reg}) - pred_reg[41:16];
        pos_sum   = pred_reg + 42'(kp_reg);
        vsum      = $signed({vel_reg[39], vel_reg}) + $signed({ki_reg[39], ki_reg});
        vmag      = vsat_reg[39] ? (40'd0 - vsat_reg) : vsat_reg;
    end

    // working registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE:   if (in_acc) begin
                load_reg <= s_tuser;
                raw_reg  <= cfg.reverse ? ~in_raw : in_raw;
            end
            ST_RD_B:   off1_reg <= ram_rd_data;
            ST_INTERP: prod_reg <= diff * $signed({1'b0, raw_reg[SEG_BITS-1:0]});
            ST_COUNT:  cnt_reg <= cnt_full[CPR_BITS-1:0];
            ST_ELEC:   elec_reg <= elec_full[CPR_BITS-1:0];
            ST_MUL_LO: mlo_reg <= cfg.sample_period * vel_reg[19:0];
            ST_MUL_HI: mhi_reg <= $signed({1'b0, cfg.sample_period}) * $signed(vel_reg[39:20]);
            ST_SUM:    full_reg <= ($signed(64'(mhi_reg)) <<< 20) + $signed({20'd0, mlo_reg});
            ST_PRED:   pred_reg <= $signed({12'd0, pos_reg}) + 42'($signed(full_reg[63:24]));
            ST_ERR:    err_reg <= half_wrap(perr);
            ST_KP:     kp_reg <= $signed({1'b0, cfg.kp_dt}) * err_reg;
            ST_KI:     ki_reg <= $signed({1'b0, cfg.ki_dt}) * err_reg;
            ST_VEL: begin
                if (vsum > $signed(41'sd549755813887))
                    vsat_reg <= 40'sd549755813887;
                else if (vsum < -$signed(41'sd549755813888))
                    vsat_reg <= -40'sd549755813888;
                else
                    vsat_reg <= vsum[39:0];
            end
            default: ;
        endcase
    end

    // tracker state and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            settle_reg    <= SETTLE_BITS'(SETTLE_SAMPLES);
            prev_reg      <= '0;
            pos_reg       <= '0;
            vel_reg       <= '0;
            turn_reg      <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_ELEC: begin
                    prev_reg <= cnt_reg;
                    if (settle_reg != '0) begin
                        settle_reg    <= settle_reg - 1'b1;
                        res_valid_reg <= 1'b0;
                    end else begin
                        turn_reg      <= turn_reg + 32'(dwrap);
                        res_valid_reg <= 1'b1;
                    end
                end
                ST_KI:   pos_reg <= pos_sum[POS_BITS-1:0];
                ST_SNAP: vel_reg <= (vmag < cfg.vel_floor) ? 40'sd0 : vsat_reg;
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_free) begin
            if (load_reg) begin
                m_tdata_reg <= '0;
                m_tuser_reg <= 1'b0;
            end else begin
                m_tdata_reg <= {6'd0, elec_reg, vel_reg, pos_reg, turn_reg, cnt_reg};
                m_tuser_reg <= res_valid_reg;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: hdl/encoder_linearize_pll_tracker.sv
// top level of the encoder linearizer and pll position/velocity tracker
//
//  channel  | direction | handshake             | payload
//  s_       | in        | s_tvalid / s_tready   | s_tdata, s_tuser = mode
//  m_       | out       | m_tvalid / m_tready   | m_tdata, m_tuser = valid_res
//  cfg_     | in        | cfg_we (no stall)     | cfg_index, cfg_wdata
//
// an angle item runs from accept to result through one shared sequencer
// with two offset-table reads and the pll multiplies done one per cycle;
// settling items skip the pll states, a table load goes straight to output.
// reset is synchronous; the table valid bits clear at once, no clearing pass.
// a finished item waits in the output register while the next one is accepted.
module encoder_linearize_pll_tracker
    import ecl_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // raw_angle[13:0], table_index[20:14], table_value[36:21], zero fill
    input  logic [39:0]              s_tdata,
    // mode
    input  logic                     s_tuser,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // count_in_turn[13:0], multi_turn_count[45:14], pll_position[75:46],
    // velocity[115:76], electrical_angle[129:116], zero fill
    output logic [135:0]             m_tdata,
    // valid_res
    output logic                     m_tuser,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

    ecl_cfg_t            cfg;
    ecl_ram_wr_t         ram_wr;
    logic [TBL_BITS-1:0] ram_rd_addr;
    logic [15:0]         ram_rd_data;

    ecl_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ecl_offset_ram u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (ram_wr),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    ecl_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .ram_wr      (ram_wr),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

endmodule
